@@ rtl/core/complex_arithmetic_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// checked property, disabled while reset is low
`define CAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cau assertion failed");

// checked property that also holds during reset
`define CAU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("cau assertion failed");

`endif

@@ rtl/core/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// opcodes and sideband type of the complex arithmetic unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       neg_re;
    logic       neg_im;
    logic       dz;
    logic       ovf_re;
    logic       ovf_im;
  } cau_side_t;

endpackage

`default_nettype wire

@@ rtl/core/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex add, subtract, multiply and divide on signed fixed point
// ----------------------------------------------------------------------------
// pipeline: stages 1 to 3, then the divide stages, then the output register
// throughput: one item per cycle while out_ready does not stall the output; the divide runs one quotient bit per stage
// stall: the whole pipeline holds while the output item waits on out_ready
// reset: synchronous active low, clears all stage valid bits, no data reset
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_im,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_res_re,
  output logic signed [DATA_WIDTH-1:0]      out_res_im,
  output logic                              out_div_zero,
  output logic                              out_saturated
);

  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;          // product width
  localparam int SW = PW + 1;          // width of a sum of two products
  localparam int NW = SW + FRAC_BITS;  // scaled dividend width

  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] RMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] RMIN = {1'b1, {(DW-1){1'b0}}};

  // global advance: every stage moves when the output is free or taken
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: the six products and add/sub ----------------
  logic signed [PW-1:0] ar_x, ai_x, br_x, bi_x;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_br_r, p_bi_r;
  logic signed [SW-1:0] as_re_nxt, as_im_nxt, as_re_r, as_im_r;
  logic [1:0]           op1_r;
  logic                 v1_r;

  assign ar_x = PW'(in_a_re);
  assign ai_x = PW'(in_a_im);
  assign br_x = PW'(in_b_re);
  assign bi_x = PW'(in_b_im);

  always_comb begin
    if (in_req_type == OP_SUB) begin
      as_re_nxt = SW'(in_a_re) - SW'(in_b_re);
      as_im_nxt = SW'(in_a_im) - SW'(in_b_im);
    end else begin
      as_re_nxt = SW'(in_a_re) + SW'(in_b_re);
      as_im_nxt = SW'(in_a_im) + SW'(in_b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      p_rr_r  <= ar_x * br_x;
      p_ii_r  <= ai_x * bi_x;
      p_ri_r  <= ar_x * bi_x;
      p_ir_r  <= ai_x * br_x;
      p_br_r  <= br_x * br_x;
      p_bi_r  <= bi_x * bi_x;
      as_re_r <= as_re_nxt;
      as_im_r <= as_im_nxt;
      op1_r   <= in_req_type;
    end
  end

  // ---------------- stage 2: sums of products ----------------
  logic signed [SW-1:0] lre_nxt, lim_nxt, lre_r, lim_r;
  logic signed [SW-1:0] dn_re_r, dn_im_r;
  logic [SW-1:0]        den_r;
  logic [1:0]           op2_r;
  logic                 v2_r;

  always_comb begin
    // lane value for the non-divide ops, multiply still unscaled
    if (op1_r == OP_MUL) begin
      lre_nxt = SW'(p_rr_r) - SW'(p_ii_r);
      lim_nxt = SW'(p_ri_r) + SW'(p_ir_r);
    end else begin
      lre_nxt = as_re_r;
      lim_nxt = as_im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      lre_r   <= lre_nxt;
      lim_r   <= lim_nxt;
      dn_re_r <= SW'(p_rr_r) + SW'(p_ii_r);
      dn_im_r <= SW'(p_ir_r) - SW'(p_ri_r);
      den_r   <= SW'(unsigned'(p_br_r)) + SW'(unsigned'(p_bi_r));
      op2_r   <= op1_r;
    end
  end

  // ------- stage 3: non-divide results finish, divide operands prepared -------
  logic signed [SW-1:0] sre, sim;
  logic [DW-1:0]        fre_nxt, fim_nxt;
  logic                 fsat_nxt;
  logic signed [NW-1:0] nre, nim;
  logic [NW-1:0]        mre_nxt, mim_nxt;
  logic [NW+DW:0]       dlim;
  cau_side_t            side_nxt;
  logic                 v3_r;

  always_comb begin
    sre = (op2_r == OP_MUL) ? (lre_r >>> FRAC_BITS) : lre_r;
    sim = (op2_r == OP_MUL) ? (lim_r >>> FRAC_BITS) : lim_r;
    fsat_nxt = 1'b0;
    if (sre > SMAX) begin
      fre_nxt  = RMAX;
      fsat_nxt = 1'b1;
    end else if (sre < SMIN) begin
      fre_nxt  = RMIN;
      fsat_nxt = 1'b1;
    end else begin
      fre_nxt = sre[DW-1:0];
    end
    if (sim > SMAX) begin
      fim_nxt  = RMAX;
      fsat_nxt = 1'b1;
    end else if (sim < SMIN) begin
      fim_nxt  = RMIN;
      fsat_nxt = 1'b1;
    end else begin
      fim_nxt = sim[DW-1:0];
    end

    // magnitudes of the scaled numerators, sign kept aside
    nre     = NW'(dn_re_r) <<< FRAC_BITS;
    nim     = NW'(dn_im_r) <<< FRAC_BITS;
    mre_nxt = nre[NW-1] ? NW'(-nre) : NW'(nre);
    mim_nxt = nim[NW-1] ? NW'(-nim) : NW'(nim);
    // quotient at or above 2^DW cannot fit the quotient bits
    dlim    = (NW+DW+1)'(den_r) << DW;

    side_nxt.op     = op2_r;
    side_nxt.neg_re = nre[NW-1];
    side_nxt.neg_im = nim[NW-1];
    side_nxt.dz     = (den_r == '0);
    side_nxt.ovf_re = ((NW+DW+1)'(mre_nxt) >= dlim);
    side_nxt.ovf_im = ((NW+DW+1)'(mim_nxt) >= dlim);
  end

  // divide pipeline taps: index 0 is stage 3, index k after k quotient bits
  logic [NW-1:0] rre_w [0:DW];
  logic [NW-1:0] rim_w [0:DW];
  logic [DW-1:0] qre_w [0:DW];
  logic [DW-1:0] qim_w [0:DW];
  logic [SW-1:0] den_w [0:DW];
  cau_side_t     side_r [0:DW];
  logic [DW-1:0] fre_r  [0:DW];
  logic [DW-1:0] fim_r  [0:DW];
  logic          fsat_r [0:DW];
  logic          vd_r   [0:DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      rre_w[0]  <= mre_nxt;
      rim_w[0]  <= mim_nxt;
      qre_w[0]  <= '0;
      qim_w[0]  <= '0;
      den_w[0]  <= den_r;
      side_r[0] <= side_nxt;
      fre_r[0]  <= fre_nxt;
      fim_r[0]  <= fim_nxt;
      fsat_r[0] <= fsat_nxt;
    end
  end

  assign vd_r[0] = v3_r;

  // ---------------- divide stages, msb first ----------------
  for (genvar k = 0; k < DW; k++) begin : g_div
    cau_divstep #(
      .NW   (NW),
      .DENW (SW),
      .QW   (DW),
      .SHIFT(DW - 1 - k)
    ) u_step (
      .clk     (clk),
      .en      (adv),
      .rem_re  (rre_w[k]),
      .rem_im  (rim_w[k]),
      .q_re    (qre_w[k]),
      .q_im    (qim_w[k]),
      .den     (den_w[k]),
      .rem_re_r(rre_w[k+1]),
      .rem_im_r(rim_w[k+1]),
      .q_re_r  (qre_w[k+1]),
      .q_im_r  (qim_w[k+1]),
      .den_r   (den_w[k+1])
    );

    // sideband rides next to the quotient
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k+1] <= 1'b0;
      end else if (adv) begin
        vd_r[k+1] <= vd_r[k];
      end
      if (adv) begin
        side_r[k+1] <= side_r[k];
        fre_r[k+1]  <= fre_r[k];
        fim_r[k+1]  <= fim_r[k];
        fsat_r[k+1] <= fsat_r[k];
      end
    end
  end

  // ---------------- output stage: sign, clamp and select ----------------
  cau_side_t     sd;
  logic [DW-1:0] qre, qim;
  logic [DW-1:0] ore_nxt, oim_nxt;
  logic          osat_nxt, odz_nxt;
  logic [DW-1:0] ore_r, oim_r;
  logic          osat_r, odz_r;

  assign sd  = side_r[DW];
  assign qre = qre_w[DW];
  assign qim = qim_w[DW];

  always_comb begin
    ore_nxt  = fre_r[DW];
    oim_nxt  = fim_r[DW];
    osat_nxt = fsat_r[DW];
    odz_nxt  = 1'b0;
    if (sd.op == OP_DIV) begin
      osat_nxt = 1'b0;
      if (sd.dz) begin
        ore_nxt = '0;
        oim_nxt = '0;
        odz_nxt = 1'b1;
      end else begin
        // positive limit is RMAX, negative magnitude may reach RMIN
        if (!sd.neg_re) begin
          if (sd.ovf_re || qre > RMAX) begin
            ore_nxt  = RMAX;
            osat_nxt = 1'b1;
          end else begin
            ore_nxt = qre;
          end
        end else begin
          if (sd.ovf_re || qre > RMIN) begin
            ore_nxt  = RMIN;
            osat_nxt = 1'b1;
          end else begin
            ore_nxt = DW'(-qre);
          end
        end
        if (!sd.neg_im) begin
          if (sd.ovf_im || qim > RMAX) begin
            oim_nxt  = RMAX;
            osat_nxt = 1'b1;
          end else begin
            oim_nxt = qim;
          end
        end else begin
          if (sd.ovf_im || qim > RMIN) begin
            oim_nxt  = RMIN;
            osat_nxt = 1'b1;
          end else begin
            oim_nxt = DW'(-qim);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd_r[DW];
    end
    if (adv) begin
      ore_r  <= ore_nxt;
      oim_r  <= oim_nxt;
      osat_r <= osat_nxt;
      odz_r  <= odz_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res_re    = ore_r;
  assign out_res_im    = oim_r;
  assign out_saturated = osat_r;
  assign out_div_zero  = odz_r;

endmodule

`default_nettype wire

@@ rtl/core/cau_divstep.sv @@
// ----------------------------------------------------------------------------
// cau_divstep
// one restoring division step for the real and imaginary lanes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_divstep #(
  parameter int NW    = 41,
  parameter int DENW  = 33,
  parameter int QW    = 16,
  parameter int SHIFT = 15
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [NW-1:0]   rem_re,
  input  wire logic [NW-1:0]   rem_im,
  input  wire logic [QW-1:0]   q_re,
  input  wire logic [QW-1:0]   q_im,
  input  wire logic [DENW-1:0] den,
  output logic      [NW-1:0]   rem_re_r,
  output logic      [NW-1:0]   rem_im_r,
  output logic      [QW-1:0]   q_re_r,
  output logic      [QW-1:0]   q_im_r,
  output logic      [DENW-1:0] den_r
);

  localparam int CW = NW + QW + 1;

  logic [CW-1:0] dsh;
  logic [CW-1:0] tr_re;
  logic [CW-1:0] tr_im;
  logic [NW-1:0] rem_re_nxt;
  logic [NW-1:0] rem_im_nxt;
  logic [QW-1:0] q_re_nxt;
  logic [QW-1:0] q_im_nxt;

  always_comb begin
    dsh        = CW'(den) << SHIFT;
    tr_re      = CW'(rem_re) - dsh;
    tr_im      = CW'(rem_im) - dsh;
    rem_re_nxt = rem_re;
    rem_im_nxt = rem_im;
    q_re_nxt   = q_re;
    q_im_nxt   = q_im;
    // no borrow means the shifted divisor fits
    if (!tr_re[CW-1]) begin
      rem_re_nxt      = tr_re[NW-1:0];
      q_re_nxt[SHIFT] = 1'b1;
    end
    if (!tr_im[CW-1]) begin
      rem_im_nxt      = tr_im[NW-1:0];
      q_im_nxt[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
      den_r    <= den;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker
// port level checks of the complex arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"

module cau_checker #(
  parameter int DATA_WIDTH = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [1:0]            in_req_type,
  input wire logic [DATA_WIDTH-1:0] in_a_re,
  input wire logic [DATA_WIDTH-1:0] in_a_im,
  input wire logic [DATA_WIDTH-1:0] in_b_re,
  input wire logic [DATA_WIDTH-1:0] in_b_im,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DATA_WIDTH-1:0] out_res_re,
  input wire logic [DATA_WIDTH-1:0] out_res_im,
  input wire logic                  out_div_zero,
  input wire logic                  out_saturated
);

  localparam logic [DATA_WIDTH-1:0] RMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] RMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                      re_rail;
  logic                      im_rail;
  logic [4*DATA_WIDTH+1:0]   in_item;

  assign re_rail = (out_res_re == RMAX) || (out_res_re == RMIN);
  assign im_rail = (out_res_im == RMAX) || (out_res_im == RMIN);
  assign in_item = {in_req_type, in_a_re, in_a_im, in_b_re, in_b_im};

  // empty output register means the pipeline is moving
  `CAU_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)

  // a waiting input item holds
  `CAU_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_item))

  // divide by zero gives a clean zero result
  `CAU_ASSERT(a_dz_zero, out_valid && out_div_zero |-> !out_saturated && !(|in_item[0] && 1'b0) && out_res_re == '0 && out_res_im == '0)

  // a clamped item shows a rail value in one of its parts
  `CAU_ASSERT(a_sat_rail, out_valid && out_saturated |-> re_rail || im_rail)

  // a stalled result item holds
  `CAU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_res_re) && $stable(out_res_im))

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// complex arithmetic unit testbench
// directed table then random add/sub/mul/div items, checked in order against
// a fixed-point predictor, under several sender/receiver idling phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 dz;
    logic                 sat;
  } cplx_result_t;

  typedef struct {
    logic [1:0]           op;
    logic signed [DW-1:0] ar, ai, br, bi;
    logic                 known;     // expected result typed in below
    cplx_result_t         res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic signed [DW-1:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic out_valid;
  logic out_ready;
  logic signed [DW-1:0] out_res_re, out_res_im;
  logic out_div_zero, out_saturated;

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_div_zero(out_div_zero), .out_saturated(out_saturated)
  );

  // expected results in order of acceptance
  cplx_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp a wide value into the signed result range
  function automatic logic signed [DW-1:0] clamp_part(input longint v, inout logic sat);
    longint hi, lo;
    hi = (64'sd1 <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic cplx_result_t predict_complex(input logic [1:0] op,
      input logic signed [DW-1:0] ar, ai, br, bi);
    longint re, im, den;
    cplx_result_t r;
    logic sat;
    re = 0;
    im = 0;
    sat = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: begin
        re = longint'(ar) + longint'(br);
        im = longint'(ai) + longint'(bi);
      end
      OP_SUB: begin
        re = longint'(ar) - longint'(br);
        im = longint'(ai) - longint'(bi);
      end
      OP_MUL: begin
        // arithmetic shift floors toward minus infinity
        re = (longint'(ar) * br - longint'(ai) * bi) >>> FB;
        im = (longint'(ar) * bi + longint'(ai) * br) >>> FB;
      end
      default: begin
        den = longint'(br) * br + longint'(bi) * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          // sv division truncates toward zero
          re = ((longint'(ar) * br + longint'(ai) * bi) * (64'sd1 <<< FB)) / den;
          im = ((longint'(ai) * br - longint'(ar) * bi) * (64'sd1 <<< FB)) / den;
        end
      end
    endcase
    r.re = clamp_part(re, sat);
    r.im = clamp_part(im, sat);
    r.sat = sat;
    return r;
  endfunction

  // sender: present one item and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic signed [DW-1:0] ar, ai, br, bi,
      input logic known, input cplx_result_t typed);
    cplx_result_t exp_res;
    exp_res = known ? typed : predict_complex(op, ar, ai, br, bi);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(exp_res);
    op_count[op]++;
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("error: result with no item pending");
      end else begin
        cplx_result_t e;
        e = pending_results.pop_front();
        if (e.re !== out_res_re || e.im !== out_res_im || e.dz !== out_div_zero
            || e.sat !== out_saturated) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp re=%0d im=%0d dz=%b sat=%b  got re=%0d im=%0d dz=%b sat=%b",
                     e.re, e.im, e.dz, e.sat, out_res_re, out_res_im, out_div_zero,
                     out_saturated);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(input logic [1:0] op, input int ar, ai, br, bi,
      input logic known = 1'b0, input int re = 0, input int im = 0,
      input logic dz = 1'b0, input logic sat = 1'b0);
    stim_row_t s;
    s.op = op;
    s.ar = ar[DW-1:0];
    s.ai = ai[DW-1:0];
    s.br = br[DW-1:0];
    s.bi = bi[DW-1:0];
    s.known = known;
    s.res.re = re[DW-1:0];
    s.res.im = im[DW-1:0];
    s.res.dz = dz;
    s.res.sat = sat;
    return s;
  endfunction

  initial begin
    logic [1:0] op;
    logic signed [DW-1:0] ar, ai, br, bi;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = OP_ADD;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    out_ready = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: extremes, every operation, divide by zero, saturation
    directed.push_back(row(OP_ADD, 0, 0, 0, 0, 1'b1, 0, 0));
    directed.push_back(row(OP_ADD, 32767, -32768, 1, -1, 1'b1, 32767, -32768, 1'b0, 1'b1));
    directed.push_back(row(OP_ADD, 32767, 32767, -32768, -32768, 1'b1, -1, -1));
    directed.push_back(row(OP_SUB, -32768, 32767, 1, -1, 1'b1, -32768, 32767, 1'b0, 1'b1));
    directed.push_back(row(OP_SUB, 256, 512, 256, 512, 1'b1, 0, 0));
    directed.push_back(row(OP_MUL, 256, 0, 256, 0, 1'b1, 256, 0));
    directed.push_back(row(OP_MUL, 0, 256, 0, 256, 1'b1, -256, 0));
    directed.push_back(row(OP_MUL, -1, 0, 1, 0));
    directed.push_back(row(OP_MUL, -32768, -32768, -32768, -32768));
    directed.push_back(row(OP_MUL, 32767, -32768, 32767, 32767));
    directed.push_back(row(OP_DIV, 256, 256, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0));
    directed.push_back(row(OP_DIV, -32768, 32767, 0, 0, 1'b1, 0, 0, 1'b1, 1'b0));
    directed.push_back(row(OP_DIV, 256, 0, 256, 0, 1'b1, 256, 0));
    directed.push_back(row(OP_DIV, -1, 1, 3, 0));
    directed.push_back(row(OP_DIV, 32767, 32767, 1, 0));
    directed.push_back(row(OP_DIV, -32768, -32768, -32768, -32768));
    directed.push_back(row(OP_DIV, -32768, 0, 0, 1));
    directed.push_back(row(OP_DIV, 100, -200, -32768, 32767));
    foreach (directed[i])
      send_item(directed[i].op, directed[i].ar, directed[i].ai, directed[i].br,
                directed[i].bi, directed[i].known, directed[i].res);

    // random part in idling phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 5 / RANDOM_ITEMS)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
        3: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
        default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
      op = 2'($urandom_range(3));
      ar = DW'($urandom);
      ai = DW'($urandom);
      br = DW'($urandom);
      bi = DW'($urandom);
      pick = $urandom_range(9);
      // small operands for four picks in ten so results stay in range, some near zero divisors
      if (pick < 4) begin
        ar = ar >>> $urandom_range(12);
        ai = ai >>> $urandom_range(12);
        br = br >>> $urandom_range(12);
        bi = bi >>> $urandom_range(12);
      end else if (pick == 4) begin
        br = (op == OP_DIV) ? '0 : br;
        bi = (op == OP_DIV) ? DW'(int'($urandom_range(2)) - 1) : bi;
      end
      send_item(op, ar, ai, br, bi, 1'b0, '0);
    end
    in_valid <= 1'b0;

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d results: add %0d, sub %0d, mul %0d, div %0d", results_seen,
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("idling phases: none, sender 87%%, receiver 87%%, both 30%%");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
